/* rtl/sar_pkg.sv */
// Shared types and constants for the SPI ADC readout responder.
// No dependencies; imported by every module under rtl.
package sar_pkg;

    localparam int CHANNEL_COUNT = 8;
    localparam int CODE_BITS     = 12;
    localparam int CODE_AW       = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
    localparam int RAW_BITS      = 16;

    localparam logic [7:0] CMD_START = 8'h01;
    localparam logic [7:0] CMD_POLL  = 8'h02;

    typedef enum logic [1:0] {
        KIND_SPI  = 2'd0,
        KIND_CONV = 2'd1,
        KIND_ERR  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_BUSY  = 2'd1,
        PH_READY = 2'd2
    } t_phase;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  command_byte;
        logic [7:0]  channel_byte;
        logic [11:0] conversion_code;
    } t_in_item;

    typedef struct packed {
        logic [1:0] status_code;
        logic [3:0] data_high;
        logic [7:0] data_low;
        logic [2:0] channel_echo;
        logic       start_conversion;
    } t_out_item;

    typedef struct packed {
        logic                 en;
        logic [CODE_AW-1:0]   addr;
        logic [CODE_BITS-1:0] data;
    } t_code_wr;

endpackage

/* rtl/sar_code_store.sv */
// Per-channel store of the last raw conversion code.
// Depends on sar_pkg for depth, code width and the write struct.
module sar_code_store
    import sar_pkg::*;
(
    input  logic                 i_clk,
    input  t_code_wr             i_wr,
    input  logic [CODE_AW-1:0]   i_rd_addr,
    output logic [CODE_BITS-1:0] o_rd_data
);

    logic [CODE_BITS-1:0] r_codes [CHANNEL_COUNT];

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_codes[i_wr.addr] <= i_wr.data;
        end
    end

    assign o_rd_data = r_codes[i_rd_addr];

endmodule

/* rtl/sar_responder.sv */
// Command decode, conversion phase tracking and response frame preparation.
// Depends on sar_pkg; reads and writes the code store through the top level.
module sar_responder
    import sar_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_go,
    input  t_in_item             i_item,
    input  logic [CODE_BITS-1:0] i_code_rd,
    output logic [CODE_AW-1:0]   o_code_rd_addr,
    output t_code_wr             o_code_wr,
    output logic                 o_has_result,
    output t_out_item            o_result
);

    logic [2:0] r_tracked, n_tracked;
    t_phase     r_phase, n_phase;
    logic [1:0] r_status, n_status;
    logic [3:0] r_high, n_high;
    logic [7:0] r_low, n_low;
    logic [2:0] r_chan, n_chan;

    logic [2:0]          ch;
    logic                tracked_ok;
    logic [RAW_BITS-1:0] raw;
    logic                start;

    assign ch         = i_item.channel_byte[2:0];
    assign tracked_ok = 32'(r_tracked) < CHANNEL_COUNT;
    assign raw        = tracked_ok ? RAW_BITS'(i_code_rd) : '0;

    assign o_code_rd_addr = CODE_AW'(r_tracked);

    always_comb begin
        n_tracked    = r_tracked;
        n_phase      = r_phase;
        n_status     = r_status;
        n_high       = r_high;
        n_low        = r_low;
        n_chan       = r_chan;
        start        = 1'b0;
        o_has_result = 1'b0;
        o_code_wr.en   = 1'b0;
        o_code_wr.addr = CODE_AW'(r_tracked);
        o_code_wr.data = CODE_BITS'(RAW_BITS'(i_item.conversion_code));
        if (i_go) begin
            unique case (i_item.kind)
                KIND_CONV: begin
                    o_code_wr.en = tracked_ok;
                    n_phase      = PH_READY;
                end
                KIND_ERR: begin
                    n_phase = PH_IDLE;
                end
                KIND_SPI: begin
                    o_has_result = 1'b1;
                    priority if (i_item.command_byte == CMD_START) begin
                        n_tracked = ch;
                        n_phase   = PH_BUSY;
                        start     = 1'b1;
                        n_status  = PH_BUSY;
                        n_high    = '0;
                        n_low     = '0;
                        n_chan    = ch;
                    end else if (i_item.command_byte == CMD_POLL) begin
                        priority if (ch != r_tracked) begin
                            n_status = (r_phase == PH_READY) ? PH_READY : PH_BUSY;
                            n_chan   = r_tracked;
                        end else if (r_phase == PH_READY) begin
                            n_status = PH_READY;
                            n_high   = raw[11:8];
                            n_low    = raw[7:0];
                            n_chan   = r_tracked;
                        end else begin
                            n_status = (r_phase == PH_BUSY) ? PH_BUSY : PH_IDLE;
                            n_high   = '0;
                            n_low    = '0;
                            n_chan   = ch;
                        end
                    end else begin
                        n_status = PH_IDLE;
                        n_high   = '0;
                        n_low    = '0;
                        n_chan   = ch;
                    end
                end
                default: begin
                end
            endcase
        end
        o_result.status_code      = n_status;
        o_result.data_high        = n_high;
        o_result.data_low         = n_low;
        o_result.channel_echo     = n_chan;
        o_result.start_conversion = start;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tracked <= '0;
            r_phase   <= PH_IDLE;
            r_status  <= PH_IDLE;
            r_high    <= '0;
            r_low     <= '0;
            r_chan    <= '0;
        end else begin
            r_tracked <= n_tracked;
            r_phase   <= n_phase;
            r_status  <= n_status;
            r_high    <= n_high;
            r_low     <= n_low;
            r_chan    <= n_chan;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_go && i_item.kind == KIND_SPI && i_item.command_byte == CMD_START)
        |=> (r_phase == PH_BUSY && r_tracked == $past(ch)))
        else $error("start did not arm the conversion");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_go && i_item.kind == KIND_CONV) |=> (r_phase == PH_READY))
        else $error("conversion complete did not mark ready");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.start_conversion |-> (o_has_result && o_result.status_code == PH_BUSY))
        else $error("start request without busy response");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_go && i_item.kind != KIND_SPI) |=> ($stable(r_status) && $stable(r_chan)))
        else $error("ADC event changed the response frame");

endmodule

/* rtl/spi_adc_readout_responder.sv */
// An input item is registered in the input stage, then its result is registered in the output stage.
// Throughput: one event per cycle; stall on the output holds both stages.
// ADC events (conversion complete, error) update state and give no result.
// Reset (i_rst_n low, synchronous) clears the channel, phase, response frame
// and both stage valid flags; stored channel codes are undefined until written.
// Depends on sar_pkg, sar_responder and sar_code_store.
module spi_adc_readout_responder
    import sar_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;

    logic                 out_free;
    logic                 go;
    logic                 has_result;
    t_out_item            result;
    t_code_wr             code_wr;
    logic [CODE_AW-1:0]   code_rd_addr;
    logic [CODE_BITS-1:0] code_rd;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign go         = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    sar_responder u_resp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_go           (go),
        .i_item         (r_in),
        .i_code_rd      (code_rd),
        .o_code_rd_addr (code_rd_addr),
        .o_code_wr      (code_wr),
        .o_has_result   (has_result),
        .o_result       (result)
    );

    sar_code_store u_store (
        .i_clk     (i_clk),
        .i_wr      (code_wr),
        .i_rd_addr (code_rd_addr),
        .o_rd_data (code_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                r_in_valid <= 1'b1;
            end else if (go) begin
                r_in_valid <= 1'b0;
            end
            if (go && has_result) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_item;
        end
        if (go && has_result) begin
            r_out <= result;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid))
        else $error("input stalled with room downstream");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_out)))
        else $error("held result lost or changed");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (go && has_result) |-> out_free)
        else $error("result overwrote a pending transfer");

endmodule
